// ===== src/mfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and constants of the mesh frame deframer
// Parser phases, result kinds, header and ack bytes, result record.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam logic [7:0] HDR_FIRST      = 8'hF1;
    localparam logic [7:0] HDR_SECOND     = 8'hDD;
    localparam int unsigned PAYLOAD_OFFSET = 7;
    // length byte counts address, skip bytes and payload
    localparam logic [7:0] LEN_OVERHEAD   = 8'(PAYLOAD_OFFSET - 3);

    localparam logic [7:0] ACK_CHAR_O  = 8'h4F;
    localparam logic [7:0] ACK_CHAR_K  = 8'h4B;
    localparam logic [7:0] ACK_CHAR_CR = 8'h0D;
    localparam logic [7:0] ACK_CHAR_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SAW_F1  = 3'd1,
        PH_LEN     = 3'd2,
        PH_ADDR_HI = 3'd3,
        PH_ADDR_LO = 3'd4,
        PH_SKIP_A  = 3'd5,
        PH_SKIP_B  = 3'd6,
        PH_PAYLOAD = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        K_ACK   = 2'd0,
        K_DATA  = 2'd1,
        K_EMPTY = 2'd2,
        K_BAD   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] peer_address;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } result_t;

    function automatic logic [7:0] ack_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = ACK_CHAR_O;
            2'd1:    c = ACK_CHAR_K;
            2'd2:    c = ACK_CHAR_CR;
            default: c = ACK_CHAR_LF;
        endcase
        return c;
    endfunction

endpackage

// ===== src/mesh_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_frame_deframer: byte-serial mesh module link parser
// Finds ack text and F1 DD framed packets, forwards payload bytes tagged
// with the peer address, and reports empty frames and bad length bytes.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid, s_ready, s_rx_byte
//  m_      | out       | m_valid, m_ready, m_kind, m_peer_address,
//          |           | m_payload_byte, m_last_of_frame
//
// One byte per cycle unless a held result stalls; a byte's result passes
// from the input register through the parser logic to the result register.
// Reset is synchronous on aresetn low and returns the parser to hunting.
// A held result stalls the parser and input register only when a new
// result would need the result register.
// ----------------------------------------------------------------------------
module mesh_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_peer_address,
    output logic [7:0]  m_payload_byte,
    output logic        m_last_of_frame
);
    import mfd_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    // consume the held byte only when its result has somewhere to go
    assign advance = byte_valid && (out_free || !res_valid);

    mfd_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .byte_valid(byte_valid),
        .byte_data (byte_data)
    );

    mfd_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .rx_byte  (byte_data),
        .res_valid(res_valid),
        .res      (res)
    );

    mfd_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .out_free(out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_kind          = m_res.kind;
    assign m_peer_address  = m_res.peer_address;
    assign m_payload_byte  = m_res.payload_byte;
    assign m_last_of_frame = m_res.last_of_frame;
endmodule

// ===== src/mfd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_in_stage: input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module mfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;
endmodule

// ===== src/mfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_parser: frame and ack parser
// Per-byte state update and result decode; state moves only on advance.
// ----------------------------------------------------------------------------
module mfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output mfd_pkg::result_t    res
);
    import mfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  ack_reg, ack_next;
    logic [7:0]  left_reg, left_next;
    logic [15:0] addr_reg, addr_next;
    logic        ack_hit;

    assign ack_hit = (rx_byte == ack_char(ack_reg));

    // next state
    always_comb begin
        phase_next = phase_reg;
        ack_next   = ack_reg;
        left_next  = left_reg;
        addr_next  = addr_reg;
        unique case (phase_reg)
            PH_HUNT, PH_SAW_F1: begin
                if (phase_reg == PH_SAW_F1 && rx_byte == HDR_SECOND) begin
                    phase_next = PH_LEN;
                    ack_next   = 2'd0;
                end else begin
                    phase_next = (rx_byte == HDR_FIRST) ? PH_SAW_F1 : PH_HUNT;
                    if (ack_hit) begin
                        ack_next = (ack_reg == 2'd3) ? 2'd0 : ack_reg + 2'd1;
                    end else begin
                        // restart the match; the byte may open a new one
                        ack_next = (rx_byte == ACK_CHAR_O) ? 2'd1 : 2'd0;
                    end
                end
            end
            PH_LEN: begin
                if (rx_byte < LEN_OVERHEAD) begin
                    phase_next = PH_HUNT;
                end else begin
                    left_next  = rx_byte - LEN_OVERHEAD;
                    phase_next = PH_ADDR_HI;
                end
            end
            PH_ADDR_HI: begin
                addr_next  = {rx_byte, 8'h00};
                phase_next = PH_ADDR_LO;
            end
            PH_ADDR_LO: begin
                addr_next  = {addr_reg[15:8], rx_byte};
                phase_next = PH_SKIP_A;
            end
            PH_SKIP_A: begin
                phase_next = PH_SKIP_B;
            end
            PH_SKIP_B: begin
                phase_next = (left_reg == 8'd0) ? PH_HUNT : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (left_reg <= 8'd1) begin
                    left_next  = 8'd0;
                    phase_next = PH_HUNT;
                end else begin
                    left_next = left_reg - 8'd1;
                end
            end
            default: phase_next = PH_HUNT;
        endcase
    end

    // result decode
    always_comb begin
        res_valid = 1'b0;
        res       = '{kind: K_ACK, peer_address: 16'h0000,
                      payload_byte: 8'h00, last_of_frame: 1'b0};
        unique case (phase_reg)
            PH_HUNT, PH_SAW_F1: begin
                if (!(phase_reg == PH_SAW_F1 && rx_byte == HDR_SECOND)
                    && ack_hit && ack_reg == 2'd3) begin
                    res_valid = 1'b1;
                end
            end
            PH_LEN: begin
                if (rx_byte < LEN_OVERHEAD) begin
                    res_valid = 1'b1;
                    res.kind  = K_BAD;
                end
            end
            PH_SKIP_B: begin
                if (left_reg == 8'd0) begin
                    res_valid        = 1'b1;
                    res.kind         = K_EMPTY;
                    res.peer_address = addr_reg;
                end
            end
            PH_PAYLOAD: begin
                res_valid         = 1'b1;
                res.kind          = K_DATA;
                res.peer_address  = addr_reg;
                res.payload_byte  = rx_byte;
                res.last_of_frame = (left_reg <= 8'd1);
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            ack_reg   <= 2'd0;
            left_reg  <= 8'd0;
            addr_reg  <= 16'h0000;
        end else if (advance) begin
            phase_reg <= phase_next;
            ack_reg   <= ack_next;
            left_reg  <= left_next;
            addr_reg  <= addr_next;
        end
    end
endmodule

// ===== src/mfd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_out_stage: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module mfd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  mfd_pkg::result_t res,
    output logic             out_free,
    output logic             m_valid,
    input  logic             m_ready,
    output mfd_pkg::result_t m_res
);
    import mfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;
endmodule
